### rtl/arp_pkg.sv
package arp_pkg;

	localparam int PosW   = 24;
	localparam int DeltaW = 16;
	localparam int KeyW   = 8;
	localparam int LimitW = 16;
	localparam int LoopsW = 17;
	localparam int IdxW   = 3;
	localparam int WideW  = 27;

	// register indexes
	localparam logic [IdxW-1:0] REG_START     = 3'd0;
	localparam logic [IdxW-1:0] REG_END       = 3'd1;
	localparam logic [IdxW-1:0] REG_START_KEY = 3'd2;
	localparam logic [IdxW-1:0] REG_END_KEY   = 3'd3;
	localparam logic [IdxW-1:0] REG_MODE      = 3'd4;
	localparam logic [IdxW-1:0] REG_LIMIT     = 3'd5;

	// loop modes; code 3 behaves as hold
	localparam logic [1:0] MODE_LOOP     = 2'd0;
	localparam logic [1:0] MODE_PINGPONG = 2'd1;
	localparam logic [1:0] MODE_HOLD     = 2'd2;

	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_RESTART = 1'b1
	} arp_cmd_t;

	typedef struct packed {
		arp_cmd_t          command;
		logic [DeltaW-1:0] time_delta;
	} arp_in_t;

	typedef struct packed {
		logic [PosW-1:0] position;
		logic            was_playing;
		logic            still_playing;
		logic            key_reached;
		logic [KeyW-1:0] key_index;
	} arp_out_t;

	typedef struct packed {
		logic [PosW-1:0]   range_start_time;
		logic [PosW-1:0]   range_end_time;
		logic [KeyW-1:0]   start_key_index;
		logic [KeyW-1:0]   end_key_index;
		logic [1:0]        loop_mode;
		logic [LimitW-1:0] loop_limit;
	} arp_cfg_t;

	typedef struct packed {
		logic              playing;
		logic [PosW-1:0]   position;
		logic              backward;
		logic [LoopsW-1:0] loops_done;
	} arp_state_t;

endpackage

### rtl/animation_range_playback_top.sv
// An accepted word passes the input register, then the step logic, then the result
// register.
// Throughput: one word per cycle while result_ready does not stall the result register;
// the position, direction and crossing count are updated in that single step and fed back for the next word.
// Reset (arst_n low): stopped, position 0, forward, no crossings, registers 0.
module animation_range_playback_top
	import arp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  arp_in_t         item,
	output logic            result_valid,
	input  logic            result_ready,
	output arp_out_t        result,
	input  logic            cfg_wen,
	input  logic [IdxW-1:0] cfg_idx,
	input  logic [PosW-1:0] cfg_wdata
);

	arp_cfg_t   cfg;
	arp_state_t st_q, st_next;
	arp_in_t    item_s1;
	logic       valid_s1;
	arp_out_t   res_comb, result_s2;
	logic       valid_s2;
	logic       advance;

	arp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	arp_step u_step (
		.cfg     (cfg),
		.st      (st_q),
		.word    (item_s1),
		.st_next (st_next),
		.res     (res_comb)
	);

	// move the held word into the result register when that one is free
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_next;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_comb;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef NO_ASSERTIONS
	// playback stops only on a step that reports a bound crossing
	a_stop_on_key: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(st_q.playing) |-> (valid_s2 && result_s2.key_reached &&
			!result_s2.still_playing))
		else $error("playback stopped without a key crossing");

	// the reported playing flag matches the state it left behind
	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> (result_s2.still_playing == st_q.playing &&
			result_s2.position == st_q.position))
		else $error("result word disagrees with updated state");

	// a crossing is only reported on a tick taken while playing
	a_key_needs_tick: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (!result_s2.key_reached || result_s2.was_playing))
		else $error("key reported on a step that was not playing");

	// an empty input register always takes a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input stalled while its register is empty");
`endif

endmodule

### rtl/arp_cfg_regs.sv
module arp_cfg_regs
	import arp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wen,
	input  logic [IdxW-1:0] cfg_idx,
	input  logic [PosW-1:0] cfg_wdata,
	output arp_cfg_t        cfg
);

	arp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_START:     cfg_q.range_start_time <= cfg_wdata;
				REG_END:       cfg_q.range_end_time   <= cfg_wdata;
				REG_START_KEY: cfg_q.start_key_index  <= cfg_wdata[KeyW-1:0];
				REG_END_KEY:   cfg_q.end_key_index    <= cfg_wdata[KeyW-1:0];
				REG_MODE:      cfg_q.loop_mode        <= cfg_wdata[1:0];
				REG_LIMIT:     cfg_q.loop_limit       <= cfg_wdata[LimitW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/arp_step.sv
module arp_step
	import arp_pkg::*;
(
	input  arp_cfg_t   cfg,
	input  arp_state_t st,
	input  arp_in_t    word,
	output arp_state_t st_next,
	output arp_out_t   res
);

	logic signed [WideW-1:0] cur_x, s_x, e_x, d_x;
	logic signed [WideW-1:0] fwd_pos, bwd_pos, over_f, over_b;
	logic signed [WideW-1:0] e_minus_f, s_plus_f, s_plus_b, e_minus_b, pos;
	logic                    fwd_cross, bwd_cross, hold, stop;
	logic [LoopsW-1:0]       loops_inc;

	always_comb begin
		cur_x = $signed({{(WideW-PosW){1'b0}}, st.position});
		s_x   = $signed({{(WideW-PosW){1'b0}}, cfg.range_start_time});
		e_x   = $signed({{(WideW-PosW){1'b0}}, cfg.range_end_time});
		d_x   = $signed({{(WideW-DeltaW){1'b0}}, word.time_delta});

		fwd_pos   = cur_x + d_x;
		bwd_pos   = cur_x - d_x;
		fwd_cross = fwd_pos >= e_x;
		bwd_cross = bwd_pos <= s_x;
		over_f    = fwd_pos - e_x;
		over_b    = s_x - bwd_pos;
		e_minus_f = e_x - over_f;
		s_plus_f  = s_x + over_f;
		s_plus_b  = s_x + over_b;
		e_minus_b = e_x - over_b;

		// saturate the crossing count
		loops_inc = (st.loops_done == '1) ? st.loops_done : st.loops_done + 1'b1;
		hold      = cfg.loop_mode[1];
		stop      = ((cfg.loop_limit != '0) &&
			(loops_inc > {{(LoopsW-LimitW){1'b0}}, cfg.loop_limit})) || hold;

		st_next = st;
		res     = '0;
		pos     = cur_x;

		if (word.command == CMD_RESTART) begin
			st_next.playing    = 1'b1;
			st_next.position   = cfg.range_start_time;
			st_next.backward   = 1'b0;
			st_next.loops_done = '0;
		end else if (st.playing) begin
			res.was_playing = 1'b1;
			if (!st.backward) begin
				pos = fwd_pos;
				if (fwd_cross) begin
					st_next.loops_done = loops_inc;
					res.key_reached    = 1'b1;
					res.key_index      = cfg.end_key_index;
					if (stop) begin
						pos             = e_x;
						st_next.playing = 1'b0;
					end else if (cfg.loop_mode == MODE_PINGPONG) begin
						st_next.backward = 1'b1;
						pos = (e_minus_f < s_x) ? s_x : e_minus_f;
					end else begin
						pos = (s_plus_f > e_x) ? e_x : s_plus_f;
					end
				end
			end else begin
				pos = bwd_pos;
				if (bwd_cross) begin
					st_next.loops_done = loops_inc;
					res.key_reached    = 1'b1;
					res.key_index      = cfg.start_key_index;
					if (stop) begin
						pos             = s_x;
						st_next.playing = 1'b0;
					end else if (cfg.loop_mode == MODE_PINGPONG) begin
						st_next.backward = 1'b0;
						pos = (s_plus_b > e_x) ? e_x : s_plus_b;
					end else begin
						pos = (e_minus_b < s_x) ? s_x : e_minus_b;
					end
				end
			end
			// floor at zero
			if (pos < 0) begin
				pos = '0;
			end
			st_next.position = pos[PosW-1:0];
		end

		res.position      = st_next.position;
		res.still_playing = st_next.playing;
	end

endmodule

### bench/arp_playback_checker.sv
module arp_playback_checker
	import arp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_ready,
	input  arp_in_t         item,
	input  logic            result_valid,
	input  logic            result_ready,
	input  arp_out_t        result,
	input  logic            cfg_wen,
	input  logic [IdxW-1:0] cfg_idx,
	input  logic [PosW-1:0] cfg_wdata,
	output int              failures,
	output int              awaiting,
	output logic            live
);
	timeunit 1ns;
	timeprecision 1ps;

	arp_cfg_t          regs;
	logic              playing;
	logic [25:0]       playhead;
	logic              backward;
	logic [LoopsW-1:0] crossings;
	arp_out_t          frames_due[$];
	int                bad_words;

	function automatic arp_out_t advance_playhead(input arp_in_t w);
		longint   lo;
		longint   hi;
		longint   p;
		longint   over;
		logic     stop;
		arp_out_t r;
		lo = longint'(regs.range_start_time);
		hi = longint'(regs.range_end_time);
		r = '0;
		if (w.command == CMD_RESTART) begin
			playhead = 26'(regs.range_start_time);
			backward = 1'b0;
			crossings = '0;
			playing = 1'b1;
		end else if (playing) begin
			r.was_playing = 1'b1;
			p = longint'(playhead);
			if (!backward) begin
				p = p + longint'(w.time_delta);
				if (p >= hi) begin
					over = p - hi;
					if (crossings != '1)
						crossings++;
					stop = (regs.loop_limit != '0 && crossings > regs.loop_limit) ||
						regs.loop_mode >= MODE_HOLD;
					if (stop) begin
						p = hi;
						playing = 1'b0;
					end else if (regs.loop_mode == MODE_PINGPONG) begin
						backward = 1'b1;
						p = hi - over;
						if (p < lo)
							p = lo;
					end else begin
						p = lo + over;
						if (p > hi)
							p = hi;
					end
					r.key_reached = 1'b1;
					r.key_index = regs.end_key_index;
				end
			end else begin
				p = p - longint'(w.time_delta);
				if (p <= lo) begin
					over = lo - p;
					if (crossings != '1)
						crossings++;
					stop = (regs.loop_limit != '0 && crossings > regs.loop_limit) ||
						regs.loop_mode >= MODE_HOLD;
					if (stop) begin
						p = lo;
						playing = 1'b0;
					end else if (regs.loop_mode == MODE_PINGPONG) begin
						backward = 1'b0;
						p = lo + over;
						if (p > hi)
							p = hi;
					end else begin
						p = hi - over;
						if (p < lo)
							p = lo;
					end
					r.key_reached = 1'b1;
					r.key_index = regs.start_key_index;
				end
			end
			if (p < 0)
				p = 0;
			playhead = p[25:0];
		end
		r.position = playhead[PosW-1:0];
		r.still_playing = playing;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		arp_out_t want;
		arp_out_t frame;
		if (!arst_n) begin
			regs = '0;
			playing = 1'b0;
			playhead = '0;
			backward = 1'b0;
			crossings = '0;
			frames_due.delete();
			bad_words = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (frames_due.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%t: unexpected word: pos %h was %b still %b key %b idx %h",
							$realtime, result.position, result.was_playing,
							result.still_playing, result.key_reached, result.key_index);
				end else begin
					want = frames_due.pop_front();
					if (result.position !== want.position ||
						result.was_playing !== want.was_playing ||
						result.still_playing !== want.still_playing ||
						result.key_reached !== want.key_reached ||
						result.key_index !== want.key_index) begin
						bad_words++;
						if (bad_words <= 10)
							$display({"%t: mismatch: expected pos %h was %b still %b key %b idx %h,",
								" got pos %h was %b still %b key %b idx %h"}, $realtime,
								want.position, want.was_playing, want.still_playing,
								want.key_reached, want.key_index, result.position,
								result.was_playing, result.still_playing,
								result.key_reached, result.key_index);
					end
				end
			end
			if (item_valid && item_ready) begin
				frame = advance_playhead(item);
				frames_due.push_back(frame);
			end
			if (cfg_wen) begin
				case (cfg_idx)
					REG_START:     regs.range_start_time = cfg_wdata;
					REG_END:       regs.range_end_time = cfg_wdata;
					REG_START_KEY: regs.start_key_index = cfg_wdata[KeyW-1:0];
					REG_END_KEY:   regs.end_key_index = cfg_wdata[KeyW-1:0];
					REG_MODE:      regs.loop_mode = cfg_wdata[1:0];
					REG_LIMIT:     regs.loop_limit = cfg_wdata[LimitW-1:0];
					default: ;
				endcase
			end
		end
		failures <= bad_words;
		awaiting <= frames_due.size();
		live <= playing;
	end

endmodule

### bench/animation_range_playback_top_test.sv
module animation_range_playback_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import arp_pkg::*;

	// spare mode code, decodes as hold
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            item_valid = 1'b0;
	logic            item_ready;
	arp_in_t         item = '0;
	logic            result_valid;
	logic            result_ready = 1'b0;
	arp_out_t        result;
	logic            cfg_wen = 1'b0;
	logic [IdxW-1:0] cfg_idx = REG_START;
	logic [PosW-1:0] cfg_wdata = '0;
	int              failures;
	int              awaiting;
	logic            live;
	bit              steady = 1'b0;

	animation_range_playback_top dut (.*);

	arp_playback_checker playback_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_word(input arp_in_t w);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IdxW-1:0] idx, input logic [PosW-1:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input arp_cfg_t c);
		put_reg(REG_START, c.range_start_time);
		put_reg(REG_END, c.range_end_time);
		put_reg(REG_START_KEY, PosW'(c.start_key_index));
		put_reg(REG_END_KEY, PosW'(c.end_key_index));
		put_reg(REG_MODE, PosW'(c.loop_mode));
		put_reg(REG_LIMIT, PosW'(c.loop_limit));
		cfg_wen <= 1'b0;
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic arp_cfg_t draw_settings();
		arp_cfg_t    c;
		int unsigned far_end;
		case ($urandom_range(0, 4))
			0:       c.range_start_time = '0;
			1:       c.range_start_time = '1;
			2:       c.range_start_time = PosW'($urandom_range(0, 'h1000));
			default: c.range_start_time = PosW'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0:       c.range_end_time = c.range_start_time;
			1:       c.range_end_time = '1;
			2:       c.range_end_time = PosW'($urandom);
			default: begin
				far_end = c.range_start_time + $urandom_range(0, 'h4000);
				if (far_end > 'hFFFFFF)
					far_end = 'hFFFFFF;
				c.range_end_time = PosW'(far_end);
			end
		endcase
		c.start_key_index = KeyW'($urandom);
		c.end_key_index = KeyW'($urandom);
		case ($urandom_range(0, 6))
			0, 1, 2: c.loop_mode = MODE_PINGPONG;
			3, 4:    c.loop_mode = MODE_LOOP;
			5:       c.loop_mode = MODE_HOLD;
			default: c.loop_mode = MODE_SPARE;
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: c.loop_limit = '0;
			3:       c.loop_limit = LimitW'($urandom_range(1, 6));
			4:       c.loop_limit = '1;
			default: c.loop_limit = LimitW'($urandom);
		endcase
		return c;
	endfunction

	function automatic arp_in_t draw_word(input arp_cfg_t c, input logic running);
		arp_in_t     w;
		int unsigned span;
		int unsigned lim;
		w.time_delta = DeltaW'($urandom);
		// restart rarely while playing, often once stopped
		if (running ? ($urandom_range(0, 39) == 0) : ($urandom_range(0, 1) == 0))
			w.command = CMD_RESTART;
		else
			w.command = CMD_TICK;
		if (c.range_end_time >= c.range_start_time)
			span = c.range_end_time - c.range_start_time;
		else
			span = c.range_start_time - c.range_end_time;
		case ($urandom_range(0, 7))
			0: ;
			1: w.time_delta = $urandom_range(0, 1) ? '1 : '0;
			default: begin
				lim = span / 3 + 8;
				if (lim > 'hFFFF)
					lim = 'hFFFF;
				w.time_delta = DeltaW'($urandom_range(0, lim));
			end
		endcase
		return c.loop_mode == MODE_HOLD && running && $urandom_range(0, 3) == 0 ?
			arp_in_t'{CMD_TICK, 16'h0000} : w;
	endfunction

	initial begin
		forever begin : result_side
			int stall;
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		arp_cfg_t now_cfg;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stopped after reset, then equal bounds at zero
		send_word(arp_in_t'{CMD_TICK, 16'hFFFF});
		send_word(arp_in_t'{CMD_RESTART, 16'h0000});
		send_word(arp_in_t'{CMD_TICK, 16'h0000});

		drain();
		load_settings(arp_cfg_t'{24'h000100, 24'h000400, 8'h5A, 8'hA5, MODE_LOOP, 16'h0000});
		send_word(arp_in_t'{CMD_RESTART, 16'h0000});
		send_word(arp_in_t'{CMD_TICK, 16'h0200});
		send_word(arp_in_t'{CMD_TICK, 16'hFFFF});
		send_word(arp_in_t'{CMD_TICK, 16'h0001});

		// top of the range, bounce both ways until the limit runs out
		drain();
		load_settings(arp_cfg_t'{24'hFFFF00, 24'hFFFFFF, 8'hFF, 8'h00, MODE_PINGPONG, 16'h0002});
		send_word(arp_in_t'{CMD_RESTART, 16'hFFFF});
		send_word(arp_in_t'{CMD_TICK, 16'h0080});
		send_word(arp_in_t'{CMD_TICK, 16'hFFFF});
		send_word(arp_in_t'{CMD_TICK, 16'h0010});
		send_word(arp_in_t'{CMD_TICK, 16'hFFFF});
		send_word(arp_in_t'{CMD_TICK, 16'h0005});

		// reversed bounds in hold
		drain();
		load_settings(arp_cfg_t'{24'h000800, 24'h000200, 8'h01, 8'h02, MODE_HOLD, 16'h0000});
		send_word(arp_in_t'{CMD_RESTART, 16'h0000});
		send_word(arp_in_t'{CMD_TICK, 16'h0000});

		drain();
		load_settings(arp_cfg_t'{24'h000010, 24'h001000, 8'h33, 8'hCC, MODE_SPARE, 16'hFFFF});
		send_word(arp_in_t'{CMD_RESTART, 16'hFFFF});
		send_word(arp_in_t'{CMD_TICK, 16'h2000});
		send_word(arp_in_t'{CMD_TICK, 16'h0000});

		// reversed bounds in loop mode clamp to the end bound
		drain();
		load_settings(arp_cfg_t'{24'h000300, 24'h000100, 8'h10, 8'h20, MODE_LOOP, 16'h0000});
		send_word(arp_in_t'{CMD_RESTART, 16'h0000});
		send_word(arp_in_t'{CMD_TICK, 16'h0010});
		send_word(arp_in_t'{CMD_TICK, 16'h0000});

		for (int ph = 0; ph < 10; ph++) begin
			drain();
			now_cfg = draw_settings();
			load_settings(now_cfg);
			steady <= ($urandom_range(0, 3) == 0);
			// keep playing across the new bounds half the time
			if ($urandom_range(0, 1) == 0)
				send_word(arp_in_t'{CMD_RESTART, DeltaW'($urandom)});
			for (int k = 0; k < 165; k++)
				send_word(draw_word(now_cfg, live));
		end

		drain();
		if (failures == 0 && awaiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
